// ===== src/two_wire_sensor_measure_master_macros.svh =====
// ----------------------------------------------------------------------------
// two-wire sensor master assertion macros
// concurrent checks, left out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef TWO_WIRE_SENSOR_MEASURE_MASTER_MACROS_SVH
`define TWO_WIRE_SENSOR_MEASURE_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// property holds on the same edge
`define TWSM_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// consequent holds on the following edge
`define TWSM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`else

`define TWSM_ASSERT(lbl, ck, rs, prop, msg)
`define TWSM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)

`endif

`endif

// ===== src/twsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twsm_pkg
// shared types and constants of the two-wire sensor master
// ----------------------------------------------------------------------------
`default_nettype none

package twsm_pkg;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_TEMP  = 2'd1;
  localparam logic [1:0] OP_HUMI  = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  // sensor command bytes
  localparam logic [7:0] CMD_TEMP = 8'h03;
  localparam logic [7:0] CMD_HUMI = 8'h05;

  localparam logic [15:0] TIMEOUT_RESET = 16'hFFFF;

  typedef struct packed {
    logic        clock_line;
    logic        data_release;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measured_value;
    logic [7:0]  checksum_byte;
    logic [1:0]  error_count;
  } res_t;

endpackage

`default_nettype wire

// ===== src/twsm_seq.sv =====
// ----------------------------------------------------------------------------
// twsm_seq
// bus phase sequencer: one line phase per step, result word out
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_seq #(
  parameter int unsigned RESET_PULSES = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step_en,
  input  wire logic [1:0]       op,
  input  wire logic             din,
  input  wire logic [15:0]      timeout_limit,
  output twsm_pkg::res_t        res
);
  import twsm_pkg::*;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_RST_HI = 5'd1;
  localparam logic [4:0] PH_RST_LO = 5'd2;
  localparam logic [4:0] PH_ST1    = 5'd3;
  localparam logic [4:0] PH_ST2    = 5'd4;
  localparam logic [4:0] PH_ST3    = 5'd5;
  localparam logic [4:0] PH_ST4    = 5'd6;
  localparam logic [4:0] PH_ST5    = 5'd7;
  localparam logic [4:0] PH_ST6    = 5'd8;
  localparam logic [4:0] PH_WR_LO  = 5'd9;
  localparam logic [4:0] PH_WR_HI  = 5'd10;
  localparam logic [4:0] PH_ACK_LO = 5'd11;
  localparam logic [4:0] PH_ACK_HI = 5'd12;
  localparam logic [4:0] PH_WAIT   = 5'd13;
  localparam logic [4:0] PH_RD_LO  = 5'd14;
  localparam logic [4:0] PH_RD_HI  = 5'd15;
  localparam logic [4:0] PH_RA_LO  = 5'd16;
  localparam logic [4:0] PH_RA_HI  = 5'd17;
  localparam logic [4:0] PH_FIN    = 5'd18;

  localparam logic [4:0] PULSE_COUNT = 5'(RESET_PULSES);

  logic [4:0]  phase, phase_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] value_store, value_store_next;
  logic [7:0]  checksum_store, checksum_store_next;
  logic [1:0]  error_store, error_store_next;
  logic [15:0] wait_counter, wait_counter_next;

  logic        clk_drv, rel_drv, busy, done;
  logic [4:0]  bit_inc;
  logic [15:0] wait_inc;
  logic [1:0]  err_inc;
  logic [7:0]  shift_in;

  assign bit_inc  = {1'b0, bit_counter} + 5'd1;
  assign wait_inc = wait_counter + 16'd1;
  assign err_inc  = (error_store == 2'd3) ? error_store : error_store + 2'd1;
  assign shift_in = {shift_byte[6:0], din};

  always_comb begin
    phase_next          = phase;
    bit_counter_next    = bit_counter;
    byte_index_next     = byte_index;
    shift_byte_next     = shift_byte;
    value_store_next    = value_store;
    checksum_store_next = checksum_store;
    error_store_next    = error_store;
    wait_counter_next   = wait_counter;
    clk_drv = 1'b0;
    rel_drv = 1'b1;
    busy    = 1'b1;
    done    = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        busy = 1'b0;
        if (op == OP_RESET) begin
          busy             = 1'b1;
          shift_byte_next  = 8'h00;  // zero command marks a reset sequence
          bit_counter_next = 4'd0;
          phase_next       = PH_RST_HI;
        end else if (op != OP_TICK) begin
          busy             = 1'b1;
          shift_byte_next  = (op == OP_TEMP) ? CMD_TEMP : CMD_HUMI;
          bit_counter_next = 4'd0;
          error_store_next = 2'd0;
          phase_next       = PH_ST1;
        end
      end
      PH_RST_HI: begin
        clk_drv    = 1'b1;
        phase_next = PH_RST_LO;
      end
      PH_RST_LO: begin
        if (bit_inc >= PULSE_COUNT) begin
          bit_counter_next = 4'd0;
          phase_next       = PH_ST1;
        end else begin
          bit_counter_next = bit_inc[3:0];
          phase_next       = PH_RST_HI;
        end
      end
      PH_ST1: begin
        clk_drv    = 1'b1;
        phase_next = PH_ST2;
      end
      PH_ST2: begin
        clk_drv    = 1'b1;
        rel_drv    = 1'b0;
        phase_next = PH_ST3;
      end
      PH_ST3: begin
        rel_drv    = 1'b0;
        phase_next = PH_ST4;
      end
      PH_ST4: begin
        clk_drv    = 1'b1;
        rel_drv    = 1'b0;
        phase_next = PH_ST5;
      end
      PH_ST5: begin
        clk_drv    = 1'b1;
        phase_next = PH_ST6;
      end
      PH_ST6: begin
        bit_counter_next = 4'd0;
        phase_next       = (shift_byte == 8'h00) ? PH_FIN : PH_WR_LO;
      end
      PH_WR_LO: begin
        rel_drv    = shift_byte[7];
        phase_next = PH_WR_HI;
      end
      PH_WR_HI: begin
        clk_drv         = 1'b1;
        rel_drv         = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (bit_inc >= 5'd8) begin
          bit_counter_next = 4'd0;
          phase_next       = PH_ACK_LO;
        end else begin
          bit_counter_next = bit_inc[3:0];
          phase_next       = PH_WR_LO;
        end
      end
      PH_ACK_LO: begin
        phase_next = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        clk_drv = 1'b1;
        if (din) begin
          error_store_next = err_inc;
        end
        wait_counter_next = 16'd0;
        phase_next        = PH_WAIT;
      end
      PH_WAIT: begin
        if (!din) begin
          phase_next = PH_RD_LO;
        end else begin
          wait_counter_next = wait_inc;
          // a limit of zero times out on the first sample
          if (wait_inc >= timeout_limit) begin
            error_store_next = err_inc;
            phase_next       = PH_RD_LO;
          end
        end
        if (phase_next == PH_RD_LO) begin
          byte_index_next  = 2'd0;
          bit_counter_next = 4'd0;
          shift_byte_next  = 8'h00;
        end
      end
      PH_RD_LO: begin
        phase_next = PH_RD_HI;
      end
      PH_RD_HI: begin
        clk_drv         = 1'b1;
        shift_byte_next = shift_in;
        if (bit_inc >= 5'd8) begin
          bit_counter_next = 4'd0;
          if (byte_index == 2'd0) begin
            value_store_next = {shift_in, value_store[7:0]};
          end else if (byte_index == 2'd1) begin
            value_store_next = {value_store[15:8], shift_in};
          end else begin
            checksum_store_next = shift_in;
          end
          phase_next = PH_RA_LO;
        end else begin
          bit_counter_next = bit_inc[3:0];
          phase_next       = PH_RD_LO;
        end
      end
      PH_RA_LO: begin
        rel_drv    = (byte_index >= 2'd2);
        phase_next = PH_RA_HI;
      end
      PH_RA_HI: begin
        clk_drv = 1'b1;
        rel_drv = (byte_index >= 2'd2);
        if (byte_index >= 2'd2) begin
          byte_index_next = 2'd0;
          phase_next      = PH_FIN;
        end else begin
          byte_index_next = byte_index + 2'd1;
          shift_byte_next = 8'h00;
          phase_next      = PH_RD_LO;
        end
      end
      PH_FIN: begin
        busy       = 1'b0;
        done       = 1'b1;
        phase_next = PH_IDLE;
      end
      default: begin
        busy       = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_counter    <= 4'd0;
      byte_index     <= 2'd0;
      shift_byte     <= 8'h00;
      value_store    <= 16'h0000;
      checksum_store <= 8'h00;
      error_store    <= 2'd0;
      wait_counter   <= 16'h0000;
    end else if (step_en) begin
      phase          <= phase_next;
      bit_counter    <= bit_counter_next;
      byte_index     <= byte_index_next;
      shift_byte     <= shift_byte_next;
      value_store    <= value_store_next;
      checksum_store <= checksum_store_next;
      error_store    <= error_store_next;
      wait_counter   <= wait_counter_next;
    end
  end

  always_comb begin
    res.clock_line     = clk_drv;
    res.data_release   = rel_drv;
    res.busy_res       = busy;
    res.done_res       = done;
    res.measured_value = value_store_next;
    res.checksum_byte  = checksum_store_next;
    res.error_count    = error_store_next;
  end

endmodule

`default_nettype wire

// ===== src/twsm_outreg.sv =====
// ----------------------------------------------------------------------------
// twsm_outreg
// result register with valid/stall handshake
// ----------------------------------------------------------------------------
`default_nettype none

module twsm_outreg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire twsm_pkg::res_t res_in,
  output logic                ready,
  output logic                out_valid,
  input  wire logic           out_stall,
  output twsm_pkg::res_t      res_out
);
  import twsm_pkg::*;

  // free when empty or when the held word leaves this edge
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/two_wire_sensor_measure_master.sv =====
// ----------------------------------------------------------------------------
// two_wire_sensor_measure_master
// two-wire sensor bus master: connection reset, start, command, acknowledge, wait, three reads
// ----------------------------------------------------------------------------
//   channel   signals                            direction  word
//   input     in_valid / in_stall                in         operation, data_line
//   result    out_valid / out_stall              out        line levels, status, stores
//   config    cfg_write_en / cfg_write_data      in         timeout_limit
//
// one word in, one word out; a word is held in the input register and is stepped
// through the phase sequencer into the result register when that register is free,
// so a new word is taken every cycle while the result side is not stalled
// rst is synchronous; it empties both registers and returns the bus to idle
// a stall on the result side holds the result word and then the input word
`default_nettype none

`include "two_wire_sensor_measure_master_macros.svh"

module two_wire_sensor_measure_master #(
  parameter int unsigned RESET_PULSES = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic        data_line,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             clock_line,
  output logic             data_release,
  output logic             busy_res,
  output logic             done_res,
  output logic [15:0]      measured_value,
  output logic [7:0]       checksum_byte,
  output logic [1:0]       error_count,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data
);
  import twsm_pkg::*;

  logic        ir_valid;
  logic [1:0]  ir_op;
  logic        ir_din;
  logic        out_ready;
  logic        advance;
  logic [15:0] timeout_limit;
  res_t        step_res;
  res_t        out_res;

  assign advance  = ir_valid && out_ready;
  assign in_stall = ir_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_limit <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_op  <= operation;
      ir_din <= data_line;
    end
  end

  twsm_seq #(
    .RESET_PULSES (RESET_PULSES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .step_en       (advance),
    .op            (ir_op),
    .din           (ir_din),
    .timeout_limit (timeout_limit),
    .res           (step_res)
  );

  twsm_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (step_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (out_res)
  );

  assign clock_line     = out_res.clock_line;
  assign data_release   = out_res.data_release;
  assign busy_res       = out_res.busy_res;
  assign done_res       = out_res.done_res;
  assign measured_value = out_res.measured_value;
  assign checksum_byte  = out_res.checksum_byte;
  assign error_count    = out_res.error_count;

  `TWSM_ASSERT(a_done_idle, clk, rst, !(out_valid && done_res) || (!busy_res && !clock_line), "done word must be idle with clock low")
  `TWSM_ASSERT(a_idle_lines, clk, rst, !(out_valid && !busy_res) || (!clock_line && data_release), "idle word must release the bus")
  `TWSM_ASSERT(a_err_range, clk, rst, !out_valid || (error_count != 2'd3), "error count beyond two")
  `TWSM_ASSERT_NEXT(a_step_loads, clk, rst, advance, out_valid, "stepped word not in result register")

endmodule

`default_nettype wire

// ===== dv/twsm_tick_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two-wire sensor master tick checker
// watches the input, result and config ports, steps its own copy of the bus
// sequencer for every accepted word and compares result words in order
// ----------------------------------------------------------------------------
module twsm_tick_checker
  import twsm_pkg::*;
#(
  parameter int unsigned PULSES = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         operation,
  input  logic               data_line,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               clock_line,
  input  logic               data_release,
  input  logic               busy_res,
  input  logic               done_res,
  input  logic [15:0]        measured_value,
  input  logic [7:0]         checksum_byte,
  input  logic [1:0]         error_count,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  typedef enum logic [4:0] {
    BUS_IDLE, BUS_RST_HI, BUS_RST_LO,
    BUS_ST1, BUS_ST2, BUS_ST3, BUS_ST4, BUS_ST5, BUS_ST6,
    BUS_WR_LO, BUS_WR_HI, BUS_ACK_LO, BUS_ACK_HI, BUS_WAIT,
    BUS_RD_LO, BUS_RD_HI, BUS_RA_LO, BUS_RA_HI, BUS_FIN
  } bus_phase_e;

  bus_phase_e  seq;
  logic [3:0]  bit_n;
  logic [1:0]  byte_n;
  logic [7:0]  shreg;
  logic [15:0] value_q;
  logic [7:0]  sum_q;
  logic [1:0]  err_q;
  logic [15:0] wait_n;
  logic [15:0] timeout_q;
  res_t        predicted_ticks[$];
  int unsigned bad;

  initial begin
    mismatches = 0;
    pending    = 0;
    bad        = 0;
  end

  function automatic void bump_error();
    if (err_q != 2'd3) err_q = err_q + 2'd1;
  endfunction

  // one bus phase per accepted word
  function automatic res_t next_bus_tick(input logic [1:0] op, input logic din);
    res_t r;
    r              = '0;
    r.data_release = 1'b1;
    r.busy_res     = 1'b1;
    case (seq)
      BUS_IDLE: begin
        r.busy_res = 1'b0;
        if (op == OP_RESET) begin
          r.busy_res = 1'b1;
          shreg      = 8'h00;   // empty command marks a connection reset
          bit_n      = 4'd0;
          seq        = BUS_RST_HI;
        end else if (op != OP_TICK) begin
          r.busy_res = 1'b1;
          shreg      = (op == OP_TEMP) ? CMD_TEMP : CMD_HUMI;
          bit_n      = 4'd0;
          err_q      = 2'd0;
          seq        = BUS_ST1;
        end
      end
      BUS_RST_HI: begin
        r.clock_line = 1'b1;
        seq          = BUS_RST_LO;
      end
      BUS_RST_LO: begin
        if (int'(bit_n) + 1 >= int'(PULSES)) begin
          bit_n = 4'd0;
          seq   = BUS_ST1;
        end else begin
          bit_n = bit_n + 4'd1;
          seq   = BUS_RST_HI;
        end
      end
      BUS_ST1: begin
        r.clock_line = 1'b1;
        seq          = BUS_ST2;
      end
      BUS_ST2: begin
        r.clock_line   = 1'b1;
        r.data_release = 1'b0;
        seq            = BUS_ST3;
      end
      BUS_ST3: begin
        r.data_release = 1'b0;
        seq            = BUS_ST4;
      end
      BUS_ST4: begin
        r.clock_line   = 1'b1;
        r.data_release = 1'b0;
        seq            = BUS_ST5;
      end
      BUS_ST5: begin
        r.clock_line = 1'b1;
        seq          = BUS_ST6;
      end
      BUS_ST6: begin
        bit_n = 4'd0;
        seq   = (shreg == 8'h00) ? BUS_FIN : BUS_WR_LO;
      end
      BUS_WR_LO: begin
        r.data_release = shreg[7];
        seq            = BUS_WR_HI;
      end
      BUS_WR_HI: begin
        r.clock_line   = 1'b1;
        r.data_release = shreg[7];
        shreg          = {shreg[6:0], 1'b0};
        if (bit_n == 4'd7) begin
          bit_n = 4'd0;
          seq   = BUS_ACK_LO;
        end else begin
          bit_n = bit_n + 4'd1;
          seq   = BUS_WR_LO;
        end
      end
      BUS_ACK_LO: seq = BUS_ACK_HI;
      BUS_ACK_HI: begin
        r.clock_line = 1'b1;
        if (din) bump_error();
        wait_n = 16'd0;
        seq    = BUS_WAIT;
      end
      BUS_WAIT: begin
        if (!din) begin
          seq = BUS_RD_LO;
        end else begin
          wait_n = wait_n + 16'd1;
          if (wait_n >= timeout_q) begin
            bump_error();
            seq = BUS_RD_LO;
          end
        end
        if (seq == BUS_RD_LO) begin
          byte_n = 2'd0;
          bit_n  = 4'd0;
          shreg  = 8'h00;
        end
      end
      BUS_RD_LO: seq = BUS_RD_HI;
      BUS_RD_HI: begin
        r.clock_line = 1'b1;
        shreg        = {shreg[6:0], din};
        if (bit_n == 4'd7) begin
          bit_n = 4'd0;
          if (byte_n == 2'd0)      value_q[15:8] = shreg;
          else if (byte_n == 2'd1) value_q[7:0]  = shreg;
          else                     sum_q         = shreg;
          seq = BUS_RA_LO;
        end else begin
          bit_n = bit_n + 4'd1;
          seq   = BUS_RD_LO;
        end
      end
      BUS_RA_LO: begin
        r.data_release = (byte_n >= 2'd2);
        seq            = BUS_RA_HI;
      end
      BUS_RA_HI: begin
        r.clock_line   = 1'b1;
        r.data_release = (byte_n >= 2'd2);
        if (byte_n >= 2'd2) begin
          byte_n = 2'd0;
          seq    = BUS_FIN;
        end else begin
          byte_n = byte_n + 2'd1;
          shreg  = 8'h00;
          seq    = BUS_RD_LO;
        end
      end
      BUS_FIN: begin
        r.busy_res = 1'b0;
        r.done_res = 1'b1;
        seq        = BUS_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        seq        = BUS_IDLE;
      end
    endcase
    r.measured_value = value_q;
    r.checksum_byte  = sum_q;
    r.error_count    = err_q;
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      seq       = BUS_IDLE;
      bit_n     = 4'd0;
      byte_n    = 2'd0;
      shreg     = 8'h00;
      value_q   = 16'h0000;
      sum_q     = 8'h00;
      err_q     = 2'd0;
      wait_n    = 16'h0000;
      timeout_q = TIMEOUT_RESET;
      predicted_ticks.delete();
      bad = 0;
    end else begin
      if (in_valid && !in_stall)
        predicted_ticks.push_back(next_bus_tick(operation, data_line));
      if (out_valid && !out_stall) begin
        if (predicted_ticks.size() == 0) begin
          $display("%0t: result word expected none actual clk=%0b rel=%0b busy=%0b done=%0b",
                   $time, clock_line, data_release, busy_res, done_res);
          bad++;
        end else begin
          want = predicted_ticks.pop_front();
          check_field("clock_line", want.clock_line, clock_line);
          check_field("data_release", want.data_release, data_release);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("done_res", want.done_res, done_res);
          check_field("measured_value", want.measured_value, measured_value);
          check_field("checksum_byte", want.checksum_byte, checksum_byte);
          check_field("error_count", want.error_count, error_count);
        end
      end
      if (cfg_write_en) timeout_q = cfg_write_data;
    end
    mismatches <= bad;
    pending    <= predicted_ticks.size();
  end

endmodule

// ===== dv/two_wire_sensor_measure_master_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_wire_sensor_measure_master_tb
// drives whole measurement and connection reset sequences with random sensor
// replies, noise words and random back-pressure; the checker does the scoring
// ----------------------------------------------------------------------------
module two_wire_sensor_measure_master_tb;
  import twsm_pkg::*;

  localparam int unsigned PULSES       = 9;
  localparam int          RANDOM_WORDS = 1100;
  localparam int          CALM_WORDS   = 250;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic [1:0]  operation      = OP_TICK;
  logic        data_line      = 1'b1;
  logic        out_stall      = 1'b0;
  logic        cfg_write_en   = 1'b0;
  logic [15:0] cfg_write_data = 16'h0000;
  logic        in_stall;
  logic        out_valid;
  logic        clock_line;
  logic        data_release;
  logic        busy_res;
  logic        done_res;
  logic [15:0] measured_value;
  logic [7:0]  checksum_byte;
  logic [1:0]  error_count;
  int unsigned mismatches;
  int unsigned pending;

  logic gaps_on     = 1'b0;
  int   stall_left  = 0;
  int   timeout_now = 65535;
  int   words       = 0;
  int   measures    = 0;
  int   resets      = 0;
  int   settings    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_wire_sensor_measure_master #(
    .RESET_PULSES (PULSES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .data_line      (data_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .clock_line     (clock_line),
    .data_release   (data_release),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .measured_value (measured_value),
    .checksum_byte  (checksum_byte),
    .error_count    (error_count),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  twsm_tick_checker #(
    .PULSES (PULSES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .data_line      (data_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .clock_line     (clock_line),
    .data_release   (data_release),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .measured_value (measured_value),
    .checksum_byte  (checksum_byte),
    .error_count    (error_count),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || !gaps_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_stall && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic rbit();
    return logic'($urandom_range(0, 1));
  endfunction

  function automatic logic [1:0] any_op();
    return 2'($urandom_range(0, 3));
  endfunction

  // present one word and hold it until taken
  task automatic put_word(input logic [1:0] op, input logic d);
    int n;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_line <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    timeout_now = v;
    settings++;
  endtask

  // ops while busy are ignored by the block, so filler words carry random ones
  task automatic run_reset();
    put_word(OP_RESET, rbit());
    repeat (2 * PULSES + 7) put_word(any_op(), rbit());
    resets++;
  endtask

  // fill: 0 reads zeros, 1 reads ones, otherwise random sensor bits
  task automatic run_measurement(input logic [1:0] op, input logic ack_bad,
                                 input int highs, input int fill);
    int  k;
    logic d;
    put_word(op, rbit());
    repeat (23) put_word(any_op(), rbit());   // start, command word, ack low
    put_word(any_op(), ack_bad);
    for (k = 0; k < highs && k < timeout_now; k++) put_word(any_op(), 1'b1);
    if (highs < timeout_now) put_word(any_op(), 1'b0);
    for (k = 0; k < 54; k++) begin
      if ((k % 18) < 16 && (k % 2) == 1)
        d = (fill == 0) ? 1'b0 : (fill == 1) ? 1'b1 : rbit();
      else
        d = rbit();
      put_word(any_op(), d);
    end
    put_word(any_op(), rbit());   // done word
    measures++;
  endtask

  task automatic random_round();
    int r;
    int highs;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      if (timeout_now <= 64 && $urandom_range(0, 2) == 0)
        highs = timeout_now;
      else
        highs = $urandom_range(0, (timeout_now - 1 < 20) ? timeout_now - 1 : 20);
      run_measurement($urandom_range(0, 1) ? OP_TEMP : OP_HUMI,
                      $urandom_range(0, 3) == 0, highs, $urandom_range(0, 9));
    end else if (r <= 7) begin
      run_reset();
    end else if (r == 8) begin
      // broken sequence, then enough quiet low words to settle back to idle
      repeat ($urandom_range(1, 8)) put_word(any_op(), rbit());
      repeat (100) put_word(OP_TICK, 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) put_word(OP_TICK, rbit());
    end
  endtask

  initial begin : stimulus
    int start;
    int stop;
    int phase_n;
    int guard;
    logic [15:0] t;

    repeat (7) @(posedge clk);
    rst     <= 1'b0;
    gaps_on <= 1'b1;

    put_word(OP_TICK, 1'b0);
    put_word(OP_TICK, 1'b1);
    run_reset();
    run_measurement(OP_TEMP, 1'b0, 0, 1);
    run_measurement(OP_HUMI, 1'b0, 3, 0);
    put_word(OP_TICK, 1'b1);
    set_timeout(16'd1);
    run_measurement(OP_TEMP, 1'b1, 5, 2);   // missing ack and timeout together
    run_measurement(OP_HUMI, 1'b0, 0, 2);
    run_reset();
    // timeout after a longer wait, run without idling
    gaps_on <= 1'b0;
    set_timeout(16'd120);
    run_measurement(OP_HUMI, 1'b1, 120, 2);

    start   = words;
    phase_n = 0;
    while (words - start < RANDOM_WORDS) begin
      case (phase_n % 4)
        0:       t = 16'd1;
        1:       t = 16'($urandom_range(2, 40));
        2:       t = 16'hFFFF;
        default: t = 16'($urandom_range(1, 65535));
      endcase
      set_timeout(t);
      phase_n++;
      stop = words + 240;
      while (words < stop && words - start < RANDOM_WORDS) begin
        if (words - start >= RANDOM_WORDS - CALM_WORDS)
          gaps_on <= 1'b0;
        else
          gaps_on <= ($urandom_range(0, 3) != 0);
        random_round();
      end
    end

    gaps_on  <= 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    $display("run covered %0d words: %0d measurements and %0d connection resets",
             words, measures, resets);
    $display("across %0d timeout settings from 1 to 65535, with random back-pressure",
             settings);
    if (pending != 0)
      $display("%0t: %0d result words expected but never seen", $time, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== two_wire_sensor_measure_master.f =====
+incdir+src
src/twsm_pkg.sv
src/twsm_seq.sv
src/twsm_outreg.sv
src/two_wire_sensor_measure_master.sv
dv/twsm_tick_checker.sv
dv/two_wire_sensor_measure_master_tb.sv
